### rtl/mdr_pkg.sv
// Shared types and constants for the message deframer and reassembler.
// Holds command and status codes, register indexes and header geometry.
// No dependencies.
`timescale 1ns / 1ps

package mdr_pkg;

  // Input request kinds, carried on s_tuser
  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Result kinds, carried on m_tuser
  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Deframer phase
  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FIRST_ID  = 2'd0;
  localparam logic [1:0] REG_SECOND_ID = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam int unsigned HEADER_BYTES = 6;
  localparam logic [2:0]  HDR_LAST_IDX = 3'(HEADER_BYTES - 1);

  // Header byte positions
  localparam logic [2:0] HDR_ID0    = 3'd0;
  localparam logic [2:0] HDR_ID1    = 3'd1;
  localparam logic [2:0] HDR_LEN_LO = 3'd2;
  localparam logic [2:0] HDR_LEN_HI = 3'd3;
  localparam logic [2:0] HDR_PKT_LO = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

endpackage

### rtl/message_deframer_reassembler_core.sv
// Top level of the message deframer and reassembler: input stage, header and
// payload tracking, result register and APB configuration registers.
// Depends on mdr_pkg.
`timescale 1ns / 1ps

// Channel   | Signals                                    | Content
// ----------+--------------------------------------------+-----------------------------------
// input     | s_tvalid s_tready s_tdata[7:0] s_tuser[1:0] | rx_byte; cmd (byte/tick/close)
// result    | m_tvalid m_tready m_tdata[7:0] m_tuser[1:0] | payload_byte; status
//           | m_tlast                                    | last_of_message
// config    | psel penable pwrite paddr[3:0] pwdata      | first_id, second_id, timeout_ms
//           | prdata pready                              | at 0x0, 0x4, 0x8
//
// One request per cycle sustained while m_tready does not stall: a request is
// captured in the input register, then decoded and folded into the deframer
// state as it advances out of that register, and its result (if any) lands
// in the result register.
// Reset (rst, synchronous) clears the state, the stages and the registers
// (timeout_ms comes back as 3000).
// A stall on m_tready holds the input register once the result register is
// full; s_tready then drops until the result is taken.

module message_deframer_reassembler_core
  import mdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] payload_byte
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast,   // last_of_message
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  first_id;
  logic [7:0]  second_id;
  logic [15:0] timeout_ms;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_id   <= '0;
      second_id  <= '0;
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_ID:  first_id   <= pwdata[7:0];
        REG_SECOND_ID: second_id  <= pwdata[7:0];
        REG_TIMEOUT:   timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_FIRST_ID:  prdata = {24'd0, first_id};
      REG_SECOND_ID: prdata = {24'd0, second_id};
      REG_TIMEOUT:   prdata = {16'd0, timeout_ms};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register and stage handshake
  // ---------------------------------------------------------------------
  logic       in_valid;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       advance;

  // The stage advances when the result slot is free or draining this cycle.
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  // ---------------------------------------------------------------------
  // Deframer state
  // ---------------------------------------------------------------------
  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic        id_mismatch, id_mismatch_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] packets_left, packets_left_next;
  logic [15:0] payload_count, payload_count_next;
  logic [16:0] elapsed_ms, elapsed_ms_next;

  // Decode of the request in the input register against current state
  logic        idle;
  logic        late;
  logic        hdr_done;
  logic        mismatch_now;
  logic [15:0] len_now;
  logic [15:0] pkt_now;
  logic [16:0] count_inc;
  logic        pay_done;

  assign idle     = (phase == PH_HEADER) && (header_index == HDR_ID0);
  assign late     = elapsed_ms > {1'b0, timeout_ms};
  assign hdr_done = header_index == HDR_LAST_IDX;

  // Fold the current byte into the header fields so the check on the last
  // header byte sees the complete header.
  assign mismatch_now = id_mismatch
                      | ((header_index == HDR_ID0) & (in_byte != first_id))
                      | ((header_index == HDR_ID1) & (in_byte != second_id));
  assign len_now = (header_index == HDR_LEN_LO) ? {payload_length[15:8], in_byte} :
                   (header_index == HDR_LEN_HI) ? {in_byte, payload_length[7:0]} :
                   payload_length;
  assign pkt_now = (header_index == HDR_PKT_LO)   ? {packets_left[15:8], in_byte} :
                   (header_index == HDR_LAST_IDX) ? {in_byte, packets_left[7:0]} :
                   packets_left;

  assign count_inc = {1'b0, payload_count} + 17'd1;
  assign pay_done  = count_inc >= {1'b0, payload_length};

  // Next state
  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    id_mismatch_next    = id_mismatch;
    payload_length_next = payload_length;
    packets_left_next   = packets_left;
    payload_count_next  = payload_count;
    elapsed_ms_next     = elapsed_ms;
    case (in_cmd)
      CMD_TICK: begin
        // Hold the timer at zero while hunting, saturate otherwise
        if (!idle && elapsed_ms != ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms + 17'd1;
        end
      end
      CMD_CLOSE: begin
        phase_next         = PH_HEADER;
        header_index_next  = '0;
        id_mismatch_next   = 1'b0;
        payload_count_next = '0;
        elapsed_ms_next    = '0;
      end
      CMD_BYTE: begin
        if (late) begin
          // Drop the late byte and hunt again
          phase_next         = PH_HEADER;
          header_index_next  = '0;
          id_mismatch_next   = 1'b0;
          payload_count_next = '0;
          elapsed_ms_next    = '0;
        end else if (phase == PH_HEADER) begin
          id_mismatch_next    = mismatch_now;
          payload_length_next = len_now;
          packets_left_next   = pkt_now;
          if (header_index == HDR_ID0) begin
            elapsed_ms_next = '0;
          end
          if (!hdr_done) begin
            header_index_next = header_index + 3'd1;
          end else if (mismatch_now || len_now == 16'd0) begin
            phase_next         = PH_HEADER;
            header_index_next  = '0;
            id_mismatch_next   = 1'b0;
            payload_count_next = '0;
            elapsed_ms_next    = '0;
          end else begin
            phase_next         = PH_PAYLOAD;
            header_index_next  = '0;
            payload_count_next = '0;
            elapsed_ms_next    = '0;
          end
        end else begin
          if (pay_done) begin
            phase_next         = PH_HEADER;
            header_index_next  = '0;
            id_mismatch_next   = 1'b0;
            payload_count_next = '0;
            elapsed_ms_next    = '0;
          end else begin
            payload_count_next = count_inc[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Result of the request
  logic       res_valid;
  status_t    res_status;
  logic [7:0] res_byte;
  logic       res_last;

  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_ERROR;
    res_byte   = '0;
    res_last   = 1'b0;
    case (in_cmd)
      CMD_CLOSE: begin
        res_valid = 1'b1;
      end
      CMD_BYTE: begin
        if (late) begin
          res_valid = 1'b1;
        end else if (phase == PH_HEADER) begin
          if (hdr_done) begin
            if (mismatch_now) begin
              res_valid = 1'b1;
            end else if (len_now == 16'd0 && pkt_now == 16'd0) begin
              // Empty final packet closes the message without a byte
              res_valid  = 1'b1;
              res_status = ST_END;
              res_last   = 1'b1;
            end
          end
        end else begin
          res_valid  = 1'b1;
          res_status = ST_BYTE;
          res_byte   = in_byte;
          res_last   = pay_done && (packets_left == 16'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_index   <= '0;
      id_mismatch    <= 1'b0;
      payload_length <= '0;
      packets_left   <= '0;
      payload_count  <= '0;
      elapsed_ms     <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      id_mismatch    <= id_mismatch_next;
      payload_length <= payload_length_next;
      packets_left   <= packets_left_next;
      payload_count  <= payload_count_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tuser <= res_status;
      m_tdata <= res_byte;
      m_tlast <= res_last;
    end
  end

endmodule

### dv/tb.sv
// Self-checking testbench for message_deframer_reassembler_core: drives the
// byte/tick/close request stream and the APB registers, predicts every result.
// Depends on mdr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mdr_pkg::*;

  // One predicted entry on the result stream
  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic        last;
  } deframe_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_byte
  logic [1:0]  s_tuser;   // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] payload_byte
  logic [1:0]  m_tuser;   // [1:0] status
  logic        m_tlast;   // last_of_message
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  message_deframer_reassembler_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor copy of the configuration registers
  logic [7:0]  id0_cfg;
  logic [7:0]  id1_cfg;
  logic [15:0] timeout_cfg;

  // Predictor copy of the deframer state
  phase_t      fr_phase;
  logic [2:0]  fr_hdr_pos;
  logic        fr_id_bad;
  logic [15:0] fr_len;
  logic [15:0] fr_left;
  logic [15:0] fr_count;
  logic [16:0] fr_ms;

  deframe_result_t expected_results[$];
  deframe_result_t want_now;

  int  mismatches;
  int  n_requests;
  int  n_payload;
  int  n_ends;
  int  n_errors;
  bit  steady;   // when set, neither side idles

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(12 * 2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void restart_hunt();
    fr_phase   = PH_HEADER;
    fr_hdr_pos = HDR_ID0;
    fr_id_bad  = 1'b0;
    fr_count   = '0;
    fr_ms      = '0;
  endfunction

  function automatic void queue_result(status_t s, logic [7:0] d, logic l);
    deframe_result_t r;
    r.status = s;
    r.data   = d;
    r.last   = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Fold one accepted request into the deframer state; queue its result if any
  function automatic void deframe_step(cmd_t c, logic [7:0] b);
    logic [16:0] next_count;
    case (c)
      CMD_TICK: begin
        // The timer only runs once a header has begun; it saturates
        if (!(fr_phase == PH_HEADER && fr_hdr_pos == HDR_ID0) && fr_ms != ELAPSED_MAX)
          fr_ms = fr_ms + 17'd1;
      end
      CMD_CLOSE: begin
        restart_hunt();
        queue_result(ST_ERROR, 8'h00, 1'b0);
      end
      CMD_BYTE: begin
        if (fr_ms > {1'b0, timeout_cfg}) begin
          // Late byte: drop it and report
          restart_hunt();
          queue_result(ST_ERROR, 8'h00, 1'b0);
        end else if (fr_phase == PH_HEADER) begin
          case (fr_hdr_pos)
            HDR_ID0: begin
              fr_ms = '0;
              if (b != id0_cfg) fr_id_bad = 1'b1;
            end
            HDR_ID1:    if (b != id1_cfg) fr_id_bad = 1'b1;
            HDR_LEN_LO: fr_len[7:0]   = b;
            HDR_LEN_HI: fr_len[15:8]  = b;
            HDR_PKT_LO: fr_left[7:0]  = b;
            default:    fr_left[15:8] = b;
          endcase
          if (fr_hdr_pos != HDR_LAST_IDX) begin
            fr_hdr_pos = fr_hdr_pos + 3'd1;
          end else if (fr_id_bad) begin
            // ID is judged only once the whole header is in
            restart_hunt();
            queue_result(ST_ERROR, 8'h00, 1'b0);
          end else if (fr_len == 16'd0) begin
            // Empty packet: ends at once, marks the message end if final
            restart_hunt();
            if (fr_left == 16'd0) queue_result(ST_END, 8'h00, 1'b1);
          end else begin
            fr_phase   = PH_PAYLOAD;
            fr_hdr_pos = HDR_ID0;
            fr_count   = '0;
            fr_ms      = '0;
          end
        end else begin
          next_count = {1'b0, fr_count} + 17'd1;
          if (next_count >= {1'b0, fr_len}) begin
            queue_result(ST_BYTE, b, fr_left == 16'd0);
            restart_hunt();
          end else begin
            fr_count = next_count[15:0];
            queue_result(ST_BYTE, b, 1'b0);
          end
        end
      end
      default: ;  // unused command: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t ns", what, want, got, $time);
  endtask

  // Randomly stall the result side, except during the steady stretch
  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing pending, status", 0, m_tuser);
      end else begin
        want_now = expected_results.pop_front();
        if (m_tuser !== want_now.status) note_mismatch("status", want_now.status, m_tuser);
        if (m_tdata !== want_now.data)   note_mismatch("payload_byte", want_now.data, m_tdata);
        if (m_tlast !== want_now.last)   note_mismatch("last_of_message", want_now.last, m_tlast);
        case (want_now.status)
          ST_BYTE: n_payload++;
          ST_END:  n_ends++;
          default: n_errors++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one request, hold it until accepted, then predict its effect
  task automatic send_req(cmd_t c, logic [7:0] b);
    if (!steady && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_step(c, b);
    if (c != CMD_UNUSED) n_requests++;
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_req(CMD_TICK, 8'($urandom));
  endtask

  // Drop valid and let everything in flight come out before touching registers
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, access, then an idle phase
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FIRST_ID:  id0_cfg     = value[7:0];
      REG_SECOND_ID: id1_cfg     = value[7:0];
      REG_TIMEOUT:   timeout_cfg = value[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(logic [1:0] idx, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) note_mismatch("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] id0, logic [7:0] id1, logic [15:0] tmo);
    wait_drained();
    cfg_write(REG_FIRST_ID, {24'h0, id0});
    cfg_write(REG_SECOND_ID, {24'h0, id1});
    cfg_write(REG_TIMEOUT, {16'h0, tmo});
    cfg_read(REG_FIRST_ID, {24'h0, id0});
    cfg_read(REG_SECOND_ID, {24'h0, id1});
    cfg_read(REG_TIMEOUT, {16'h0, tmo});
  endtask

  // One packet: header (optionally with a corrupted ID byte) and payload,
  // with random millisecond ticks sprinkled between bytes
  task automatic send_packet(logic [15:0] len, logic [15:0] left, bit bad_id, int tick_pct);
    logic [7:0] hdr [0:5];
    int k;
    hdr[0] = id0_cfg;
    hdr[1] = id1_cfg;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    hdr[4] = left[7:0];
    hdr[5] = left[15:8];
    if (bad_id) begin
      k = $urandom_range(1);
      hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < HEADER_BYTES + len; i++) begin
      if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 3));
      send_req(CMD_BYTE, (i < HEADER_BYTES) ? hdr[i] : 8'($urandom));
    end
  endtask

  // If a dropped byte left the deframer mid-packet, close the link to realign
  task automatic realign_to_header();
    if (!(fr_phase == PH_HEADER && fr_hdr_pos == HDR_ID0))
      send_req(CMD_CLOSE, 8'($urandom));
  endtask

  // A message of one to three packets, packets-left counting down to zero;
  // non-final packets often carry an arbitrary nonzero count
  task automatic send_message(int tick_pct);
    int npk;
    int r;
    logic [15:0] len;
    logic [15:0] left;
    npk = $urandom_range(1, 3);
    for (int i = 0; i < npk; i++) begin
      if (i == npk - 1)
        left = 16'd0;
      else if ($urandom_range(2) == 0)
        left = 16'($urandom_range(1, 65535));
      else
        left = 16'(npk - 1 - i);
      r = $urandom_range(99);
      if (r < 12)      len = 16'd0;
      else if (r < 97) len = 16'($urandom_range(1, 8));
      else             len = 16'($urandom_range(9, 40));
      send_packet(len, left, $urandom_range(99) < 6, tick_pct);
    end
    realign_to_header();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_access();
    cfg_read(REG_FIRST_ID, 32'h0);
    cfg_read(REG_SECOND_ID, 32'h0);
    cfg_read(REG_TIMEOUT, {16'h0, TIMEOUT_RESET});
    apply_config(8'hC3, 8'h3C, 16'd1);
  endtask

  // Final single-byte packet, final empty packet, close while idle, unused cmd
  task automatic test_basic_framing();
    send_req(CMD_BYTE, id0_cfg);
    send_req(CMD_BYTE, id1_cfg);
    send_req(CMD_BYTE, 8'h01);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'hFF);
    send_packet(16'd0, 16'd0, 1'b0, 0);
    send_req(CMD_CLOSE, 8'hFF);
    send_req(CMD_UNUSED, 8'hA5);
  endtask

  // With a 1 ms limit: elapsed equal to the limit passes, one more fails,
  // in the header phase and then in the payload phase
  task automatic test_phase_timeout();
    send_req(CMD_BYTE, id0_cfg);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_BYTE, id1_cfg);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    // Header of a two-byte final packet, then its payload under the timer
    send_req(CMD_BYTE, id0_cfg);
    send_req(CMD_BYTE, id1_cfg);
    send_req(CMD_BYTE, 8'h02);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_BYTE, 8'h80);
    realign_to_header();
  endtask

  // A payload length with its high byte set
  task automatic test_long_payload();
    send_packet(16'h0101, 16'd0, 1'b0, 0);
  endtask

  // Mostly well-formed messages, plus noise, stray ticks, closes, unused
  // commands and headers cut short
  task automatic test_random_traffic(logic [7:0] id0, logic [7:0] id1, logic [15:0] tmo,
                                     int tick_pct, int budget);
    int start;
    int r;
    apply_config(id0, id1, tmo);
    start = n_requests;
    while (n_requests - start < budget) begin
      r = $urandom_range(99);
      if (r < 78) begin
        send_message(tick_pct);
      end else if (r < 86) begin
        repeat ($urandom_range(1, 4)) send_req(CMD_BYTE, 8'($urandom));
      end else if (r < 91) begin
        send_ticks($urandom_range(1, 3));
      end else if (r < 95) begin
        send_req(CMD_CLOSE, 8'($urandom));
      end else if (r < 97) begin
        send_req(CMD_UNUSED, 8'($urandom));
      end else begin
        send_req(CMD_BYTE, id0_cfg);
        repeat ($urandom_range(0, 4)) send_req(CMD_BYTE, 8'($urandom));
        send_req(CMD_CLOSE, 8'($urandom));
      end
      realign_to_header();
    end
  endtask

  initial begin
    // Known values on every input from time zero
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= CMD_BYTE;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 4'h0;
    pwdata   <= 32'h0;
    steady   = 1'b0;
    id0_cfg     = 8'h00;
    id1_cfg     = 8'h00;
    timeout_cfg = TIMEOUT_RESET;
    fr_len      = '0;
    fr_left     = '0;
    restart_hunt();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_basic_framing();
    test_phase_timeout();
    test_long_payload();

    test_random_traffic(8'h00, 8'h00, 16'd1, 12, 290);
    steady = 1'b1;
    test_random_traffic(8'hFF, 8'hFF, 16'hFFFF, 10, 290);
    steady = 1'b0;
    test_random_traffic(8'($urandom), 8'($urandom), 16'($urandom_range(2, 6)), 20, 290);
    test_random_traffic(8'($urandom), 8'($urandom), 16'd3000, 10, 290);
    test_random_traffic(8'($urandom), 8'($urandom), 16'($urandom_range(1, 4)), 15, 290);

    wait_drained();

    $display("Run covered %0d requests (ticks included) over six register settings.", n_requests);
    $display("Checked %0d payload bytes, %0d message ends and %0d framing errors; %0d mismatches.",
             n_payload, n_ends, n_errors, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
